// ----- design/ffha_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants for the first-fit heap allocator
// Request and response payloads, the internal command format and status codes.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_BYTES_DEF = 1 << 20;
    localparam int WORD_BYTES_DEF = 8;

    localparam int SIZE_W = 21;
    localparam int WORD_W = 17;
    // Rounded-up word count for the largest request with the smallest word size.
    localparam int NEED_W = 20;
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_BADFREE = 2'd2
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        K_ALLOC = 2'd0,
        K_ZERO  = 2'd1,
        K_FREE  = 2'd2,
        K_NULL  = 2'd3
    } t_kind;

    typedef struct packed {
        t_op                op;
        logic [SIZE_W-1:0]  size_bytes;
        logic [WORD_W-1:0]  payload_word;
        logic               no_pointer;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0]  result_word;
        t_status            status;
    } t_resp;

    typedef struct packed {
        t_kind              kind;
        logic [NEED_W-1:0]  need;
        logic [WORD_W-1:0]  addr;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_qwr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ----- design/ffha_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_front: request intake and classification
// Rounds allocation sizes to words and sorts out the trivial cases up front.
// ----------------------------------------------------------------------------
module ffha_front #(
    parameter int WORD_BYTES = ffha_pkg::WORD_BYTES_DEF
) (
    input  logic           i_in_valid,
    input  ffha_pkg::t_req i_in_req,
    input  ffha_pkg::t_qstat i_qstat,
    output logic           o_in_stall,
    output ffha_pkg::t_qwr o_qwr
);
    import ffha_pkg::*;

    // The word size is a power of two, so the division is a shift.
    localparam int WB_SHIFT = $clog2(WORD_BYTES);

    logic [SIZE_W:0] rounded;

    always_comb begin
        rounded = {1'b0, i_in_req.size_bytes} + (SIZE_W + 1)'(WORD_BYTES - 1);
        o_qwr.cmd.need = NEED_W'(rounded >> WB_SHIFT);
        o_qwr.cmd.addr = i_in_req.payload_word;
        if (i_in_req.op == OP_ALLOC) begin
            o_qwr.cmd.kind = (i_in_req.size_bytes == '0) ? K_ZERO : K_ALLOC;
        end else begin
            o_qwr.cmd.kind = i_in_req.no_pointer ? K_NULL : K_FREE;
        end
        o_qwr.push = i_in_valid && !i_qstat.full;
        o_in_stall = i_qstat.full;
    end

endmodule

// ----- design/ffha_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_queue: command queue between intake and execution
// A small register FIFO so that either side can stall independently.
// ----------------------------------------------------------------------------
module ffha_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ffha_pkg::t_qwr   i_wr,
    input  logic             i_pop,
    output ffha_pkg::t_qstat o_qstat,
    output ffha_pkg::t_cmd   o_cmd
);
    import ffha_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_cmd             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [PTR_W:0]   r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_wr.push) begin
            n_wptr = (r_wptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_wr.push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr.push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wptr] <= i_wr.cmd;
        end
    end

    assign o_cmd         = r_mem[r_rptr];
    assign o_qstat.full  = (r_count == (PTR_W + 1)'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);

endmodule

// ----- design/ffha_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_back: command execution over the header memory
// Walks block headers one read per cycle, reuses or appends blocks, marks frees.
// ----------------------------------------------------------------------------
module ffha_back #(
    parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF,
    parameter int WORD_BYTES = ffha_pkg::WORD_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ffha_pkg::t_qstat i_qstat,
    input  ffha_pkg::t_cmd   i_cmd,
    output logic             o_pop,
    output logic             o_out_valid,
    output ffha_pkg::t_resp  o_out_resp,
    input  logic             i_out_stall
);
    import ffha_pkg::*;

    localparam int HW = HEAP_BYTES / WORD_BYTES;
    localparam int AW = $clog2(HW);
    localparam int XW = (AW + 3 > NEED_W + 2) ? AW + 3 : NEED_W + 2;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WALK = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    // Header memory, split into the size field and the free mark so that a
    // free only has to write the mark.
    logic [AW-1:0] r_size_mem [HW];
    logic          r_free_mem [HW];

    t_state        r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [AW:0]   r_end, n_end;
    logic [AW:0]   r_pos, n_pos;
    t_resp         r_res, n_res;
    logic          r_out_valid, n_out_valid;
    t_resp         r_out, n_out;
    logic [AW-1:0] r_rd_size;
    logic          r_rd_free;

    logic [AW-1:0] rd_addr;
    logic          wr_free_en, wr_free_val;
    logic [AW-1:0] wr_free_addr;
    logic          wr_size_en;
    logic          do_append;

    logic [XW-1:0] end_x, need_x, addr_x, hw_x;
    logic [XW-1:0] npos_x, end_inc_x, app_end_x, pos_inc_x, addr_dec_x;
    logic          fit;

    always_comb begin
        end_x      = XW'(r_end);
        need_x     = XW'(r_cmd.need);
        addr_x     = XW'(r_cmd.addr);
        hw_x       = XW'(HW);
        end_inc_x  = end_x + 1'b1;
        app_end_x  = end_inc_x + need_x;
        pos_inc_x  = XW'(r_pos) + 1'b1;
        npos_x     = pos_inc_x + XW'(r_rd_size);
        addr_dec_x = addr_x - 1'b1;
        fit        = r_rd_free && (XW'(r_rd_size) >= need_x);
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_end        = r_end;
        n_pos        = r_pos;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        o_pop        = 1'b0;
        rd_addr      = '0;
        wr_free_en   = 1'b0;
        wr_free_val  = 1'b0;
        wr_free_addr = '0;
        wr_size_en   = 1'b0;
        do_append    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
                case (r_cmd.kind)
                    K_ZERO: begin
                        n_res.result_word = '0;
                        n_res.status      = ST_NOMEM;
                    end
                    K_NULL: begin
                        n_res.result_word = '0;
                        n_res.status      = ST_OK;
                    end
                    K_FREE: begin
                        n_res.result_word = '0;
                        if (addr_x == '0 || addr_x >= end_x || addr_x > hw_x) begin
                            n_res.status = ST_BADFREE;
                        end else begin
                            wr_free_en   = 1'b1;
                            wr_free_val  = 1'b1;
                            wr_free_addr = addr_dec_x[AW-1:0];
                            n_res.status = ST_OK;
                        end
                    end
                    K_ALLOC: begin
                        if (r_end == '0) begin
                            do_append = 1'b1;
                        end else begin
                            rd_addr = '0;
                            n_pos   = '0;
                            n_state = S_WALK;
                        end
                    end
                    default: begin
                        n_res.result_word = '0;
                        n_res.status      = ST_NOMEM;
                    end
                endcase
            end
            S_WALK: begin
                if (fit) begin
                    wr_free_en        = 1'b1;
                    wr_free_val       = 1'b0;
                    wr_free_addr      = r_pos[AW-1:0];
                    n_res.result_word = WORD_W'(pos_inc_x);
                    n_res.status      = ST_OK;
                    n_state           = S_RESP;
                end else if (npos_x < end_x && npos_x < hw_x) begin
                    rd_addr = npos_x[AW-1:0];
                    n_pos   = npos_x[AW:0];
                end else begin
                    do_append = 1'b1;
                end
            end
            S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_append) begin
            n_state = S_RESP;
            if (app_end_x > hw_x) begin
                n_res.result_word = '0;
                n_res.status      = ST_NOMEM;
            end else begin
                wr_size_en        = 1'b1;
                wr_free_en        = 1'b1;
                wr_free_val       = 1'b0;
                wr_free_addr      = r_end[AW-1:0];
                n_end             = app_end_x[AW:0];
                n_res.result_word = WORD_W'(end_inc_x);
                n_res.status      = ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_end       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_end       <= n_end;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_pos <= n_pos;
        r_res <= n_res;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_size_en) begin
            r_size_mem[r_end[AW-1:0]] <= AW'(r_cmd.need);
        end
        if (wr_free_en) begin
            r_free_mem[wr_free_addr] <= wr_free_val;
        end
        r_rd_size <= r_size_mem[rd_addr];
        r_rd_free <= r_free_mem[rd_addr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_resp  = r_out;

endmodule

// ----- design/first_fit_heap_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core: first-fit allocator over an implicit free list
// Frees and trivial requests need no header walk; an allocation walks block
// headers from the first. The back end finishes one request before it pops
// the next and walks one header per cycle on the single header read port.
// Reset empties the heap and the request queue; the header memory is not
// cleared, since the walk only ever reads headers that were written.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core #(
    parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF,
    parameter int WORD_BYTES = ffha_pkg::WORD_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  ffha_pkg::t_req  i_in_req,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output ffha_pkg::t_resp o_out_resp,
    input  logic            i_out_stall
);
    import ffha_pkg::*;

    // The front end classifies each request and pushes a command into the
    // queue. It only stalls the requester when the queue is full.
    t_qwr   qwr;
    t_qstat qstat;
    t_cmd   q_cmd;
    logic   q_pop;

    ffha_front #(
        .WORD_BYTES (WORD_BYTES)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_in_req   (i_in_req),
        .i_qstat    (qstat),
        .o_in_stall (o_in_stall),
        .o_qwr      (qwr)
    );

    // The queue decouples intake from execution, so a new request can be
    // taken while the back end is still walking headers for an earlier one.
    ffha_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (qwr),
        .i_pop   (q_pop),
        .o_qstat (qstat),
        .o_cmd   (q_cmd)
    );

    // The back end owns the header memory and the heap end. Its response
    // goes through an output register, so a stalled response does not block
    // the queue from filling.
    ffha_back #(
        .HEAP_BYTES (HEAP_BYTES),
        .WORD_BYTES (WORD_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (qstat),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_resp  (o_out_resp),
        .i_out_stall (i_out_stall)
    );

endmodule

// ----- design/ffha_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_checker: port-level checks for the first-fit heap allocator
// Tracks outstanding requests and checks response behavior over time.
// ----------------------------------------------------------------------------
module ffha_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input logic            o_out_valid,
    input ffha_pkg::t_resp o_out_resp,
    input logic            i_out_stall
);
    import ffha_pkg::*;

    logic [2:0] r_cnt, n_cnt;
    logic       in_acc, out_acc;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    always_comb begin
        n_cnt = r_cnt;
        if (in_acc && !out_acc) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!in_acc && out_acc) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // No response is shown right after reset.
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("response valid right after reset");

    // A stalled response holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_resp))
        else $error("stalled response changed");

    // Every failure carries a zero address.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_resp.status != ST_OK |-> o_out_resp.result_word == '0)
        else $error("failed response with nonzero address");

    // A response always belongs to an accepted request.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_cnt != '0)
        else $error("response without an outstanding request");

    // Queue, execution and output register bound the requests in flight.
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("too many requests in flight");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (.*);
